// File: src/jvad_pkg.sv
`default_nettype none
package jvad_pkg;

  // Default number of history slots; the slot index wraps at this count.
  localparam int HistoryDepthDef = 64;

  // Fixed-point layout of the quotient: (difference * 2^24) / dt.
  localparam int FracBits = 24;
  localparam int MagW     = 33;
  localparam int QuotW    = MagW + FracBits;
  localparam int DivSteps = QuotW;
  localparam int CntW     = $clog2(DivSteps + 1);

  // Number of divisions per word: velocity and acceleration for three axes.
  localparam int NumDivs  = 6;
  localparam int IdxW     = $clog2(NumDivs);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic        [5:0]  slot;
    logic               saturated;
    logic               zero_step;
  } out_word_t;

  // Request to the shared divider: magnitude of the difference and its sign.
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [MagW-1:0]   mag;
  } div_req_t;

  // Divider answer, valid for the one cycle in which done is high.
  typedef struct packed {
    logic               done;
    logic               clip;
    logic signed [31:0] quot;
  } div_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

// File: src/jvad_div.sv
`default_nettype none
module jvad_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire jvad_pkg::div_req_t req_i,
  input  wire logic [31:0]       divisor_i,
  output jvad_pkg::div_res_t     res_o
);

  logic [jvad_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic                       neg_q, neg_d;
  logic [32:0]                rem_q, rem_d;
  logic [jvad_pkg::QuotW-1:0] dvd_q, dvd_d;
  logic [32:0]                rem_shift;
  logic                       fits;
  logic [31:0]                quot_lo;

  // One restoring step per cycle: shift in the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    rem_shift = {rem_q[31:0], dvd_q[jvad_pkg::QuotW-1]};
    fits      = rem_shift >= {1'b0, divisor_i};
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    neg_d     = neg_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    if (req_i.start) begin
      cnt_d = jvad_pkg::CntW'(jvad_pkg::DivSteps);
      neg_d = req_i.neg;
      rem_d = '0;
      dvd_d = {req_i.mag, {jvad_pkg::FracBits{1'b0}}};
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == jvad_pkg::CntW'(1));
      rem_d  = fits ? (rem_shift - {1'b0, divisor_i}) : rem_shift;
      dvd_d  = {dvd_q[jvad_pkg::QuotW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  // Apply the sign and clip the finished quotient to the signed 32-bit range.
  always_comb begin
    quot_lo    = dvd_q[31:0];
    res_o.done = done_q;
    res_o.clip = 1'b0;
    if (neg_q) begin
      if (dvd_q > jvad_pkg::QuotW'(32'h8000_0000)) begin
        res_o.clip = 1'b1;
        res_o.quot = 32'sh8000_0000;
      end else begin
        res_o.quot = $signed(32'd0 - quot_lo);
      end
    end else begin
      if (dvd_q > jvad_pkg::QuotW'(32'h7FFF_FFFF)) begin
        res_o.clip = 1'b1;
        res_o.quot = 32'sh7FFF_FFFF;
      end else begin
        res_o.quot = $signed(quot_lo);
      end
    end
  end

endmodule
`default_nettype wire

// File: src/joint_velocity_acceleration_diff_core.sv
`default_nettype none
// Each accepted word runs six divisions in turn on one shared bit-serial divider, and its
// result is then held until it is taken.
// A zero time step skips the divider and gives its result in the cycle after acceptance.
// Throughput: one word at a time; the next word can be taken in the cycle after the result
// is taken.
// Reset (asynchronous, active low) clears last position and velocity to zero and sets
// the slot counter to its last value, so the first nonzero-step sample gets slot 0.
module joint_velocity_acceleration_diff_core #(
  parameter int HISTORY_DEPTH = jvad_pkg::HistoryDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire jvad_pkg::in_word_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output jvad_pkg::out_word_t      out_data_o
);

  localparam int SlotW = $clog2(HISTORY_DEPTH);

  jvad_pkg::state_e state_q, state_d;

  logic signed [31:0] pos_q      [3];
  logic        [31:0] dt_q;
  logic signed [31:0] prev_pos_q [3];
  logic signed [31:0] prev_vel_q [3];
  logic signed [31:0] vel_q      [3];
  logic signed [31:0] acc_q      [3];
  logic [SlotW-1:0]   slot_q;
  logic [SlotW+5:0]   slot_ext;
  logic               sat_q;
  logic               zero_q;
  logic [jvad_pkg::IdxW-1:0] idx_q;
  logic [1:0]         axis;
  logic               is_acc;

  logic               accept;
  logic               div_start;
  logic signed [32:0] diff;
  logic signed [31:0] op_a, op_b;
  jvad_pkg::div_req_t div_req;
  jvad_pkg::div_res_t div_res;

  assign accept = in_valid_i && in_ready_o;
  assign axis   = idx_q[jvad_pkg::IdxW-1:1];
  assign is_acc = idx_q[0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jvad_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.time_step == '0) ? jvad_pkg::ST_OUT : jvad_pkg::ST_LOAD;
        end
      end
      jvad_pkg::ST_LOAD: state_d = jvad_pkg::ST_WAIT;
      jvad_pkg::ST_WAIT: begin
        if (div_res.done) begin
          state_d = (idx_q == jvad_pkg::IdxW'(jvad_pkg::NumDivs - 1)) ?
                    jvad_pkg::ST_OUT : jvad_pkg::ST_LOAD;
        end
      end
      jvad_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = jvad_pkg::ST_IDLE;
        end
      end
      default: state_d = jvad_pkg::ST_IDLE;
    endcase
  end

  // Handshake and divider control outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      jvad_pkg::ST_IDLE: in_ready_o  = 1'b1;
      jvad_pkg::ST_LOAD: div_start   = 1'b1;
      jvad_pkg::ST_WAIT: ;
      jvad_pkg::ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Difference for the current division: position step or velocity step.
  always_comb begin
    op_a = is_acc ? vel_q[axis] : pos_q[axis];
    op_b = is_acc ? prev_vel_q[axis] : prev_pos_q[axis];
    diff = {op_a[31], op_a} - {op_b[31], op_b};
    div_req.start = div_start;
    div_req.neg   = diff[32];
    div_req.mag   = diff[32] ? (33'd0 - $unsigned(diff)) : $unsigned(diff);
  end

  jvad_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (dt_q),
    .res_o     (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jvad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Stored history and sequencing; reset clears the last values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        prev_pos_q[i] <= '0;
        prev_vel_q[i] <= '0;
      end
      slot_q <= SlotW'(HISTORY_DEPTH - 1);
      idx_q  <= '0;
    end else begin
      if (accept) begin
        idx_q <= '0;
        if (in_data_i.time_step != '0) begin
          slot_q <= (slot_q == SlotW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        end
      end
      // The new position replaces the old once its difference is in the divider.
      if (div_start && !is_acc) begin
        prev_pos_q[axis] <= pos_q[axis];
      end
      if (div_res.done) begin
        if (is_acc) begin
          prev_vel_q[axis] <= vel_q[axis];
        end
        if (idx_q != jvad_pkg::IdxW'(jvad_pkg::NumDivs - 1)) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // Input word capture and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q[0] <= in_data_i.pos_x;
      pos_q[1] <= in_data_i.pos_y;
      pos_q[2] <= in_data_i.pos_z;
      dt_q     <= in_data_i.time_step;
      sat_q    <= 1'b0;
      zero_q   <= (in_data_i.time_step == '0);
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else if (div_res.done) begin
      sat_q <= sat_q | div_res.clip;
      if (is_acc) begin
        acc_q[axis] <= div_res.quot;
      end else begin
        vel_q[axis] <= div_res.quot;
      end
    end
  end

  // Result word, held steady while it waits to be taken.
  assign slot_ext = {6'd0, slot_q};

  always_comb begin
    out_data_o.vel_x     = vel_q[0];
    out_data_o.vel_y     = vel_q[1];
    out_data_o.vel_z     = vel_q[2];
    out_data_o.acc_x     = acc_q[0];
    out_data_o.acc_y     = acc_q[1];
    out_data_o.acc_z     = acc_q[2];
    out_data_o.slot      = slot_ext[5:0];
    out_data_o.saturated = sat_q;
    out_data_o.zero_step = zero_q;
  end

endmodule
`default_nettype wire
